// ===== hw/rtl/tkis_pkg.sv =====
package tkis_pkg;

   localparam int K_MAX      = 64;
   localparam int N_MAX      = 4096;
   localparam int SCORE_BITS = 32;
   localparam int IDX_BITS   = 12;
   localparam int SEEN_BITS  = $clog2(N_MAX + 1);
   localparam int SEL_BITS   = 7;
   localparam int SLOT_BITS  = $clog2(K_MAX);

   typedef logic signed [SCORE_BITS-1:0] score_type;
   typedef logic [IDX_BITS-1:0]          index_type;
   typedef logic [SEL_BITS-1:0]          sel_type;

   // commands from the controller to the slot chain
   typedef struct packed {
      logic insert;     // take in the accepted score
      logic emit;       // load the head slot into the output register and shift up
      logic last_word;  // the emitted word closes the run
      logic clear;      // drop the whole set
   } dp_cmd_type;

endpackage

// ===== hw/rtl/top_k_index_selector_top.sv =====
// top-k index selector
// req channel: one signed score word per cycle, req_last closes the set; the
// position of a score within its set is its index
// the scores are kept in a 64-slot sorted insertion chain; every slot compares
// against the new score in parallel, so a score word is taken every cycle
// while the set streams in
// on the word marked last, req_stall rises and the block sends select_count
// (at most 64) rsp words in order of decreasing score, equal scores earliest
// index first: one word per cycle while rsp_stall does not hold it, the first
// one after the state register and then the output word register are loaded
// slots with no score come out with rsp_valid_res low and index zero;
// rsp_final_res marks the closing word, rsp_overflow flags a set that had more
// than 4096 scores (the extra ones are dropped)
// a stalled rsp word holds, and the chain waits with it; the next set is
// taken as soon as the closing word sits in the output register
// csr_we/csr_wdata write select_count (reset value 64, zero acts as one); write
// only while no set is in flight
// reset (synchronous) empties the chain and clears the output valid
module top_k_index_selector_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tkis_pkg::score_type req_score,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tkis_pkg::index_type rsp_index,
   output logic                rsp_valid_res,
   output logic                rsp_final_res,
   output logic                rsp_overflow,
   input  logic                csr_we,
   input  tkis_pkg::sel_type   csr_wdata
);
   import tkis_pkg::*;

   dp_cmd_type cmd;

   tkis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   tkis_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_score     (req_score),
      .rsp_index     (rsp_index),
      .rsp_valid_res (rsp_valid_res),
      .rsp_final_res (rsp_final_res),
      .rsp_overflow  (rsp_overflow)
   );

   a_last_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last) |=> req_stall)
      else $error("input not held off after closing word");

   a_empty_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_index == '0))
      else $error("empty slot with nonzero index");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_final_res) |=> rsp_valid)
      else $error("result run broken before closing word");

   a_emit_blocks_input: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> req_stall)
      else $error("input taken while emitting");

endmodule

// ===== hw/rtl/tkis_datapath.sv =====
module tkis_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  tkis_pkg::dp_cmd_type cmd,
   input  tkis_pkg::score_type  req_score,
   output tkis_pkg::index_type  rsp_index,
   output logic                 rsp_valid_res,
   output logic                 rsp_final_res,
   output logic                 rsp_overflow
);
   import tkis_pkg::*;

   score_type             slot_score_ff [K_MAX];
   score_type             slot_score_in [K_MAX];
   index_type             slot_index_ff [K_MAX];
   index_type             slot_index_in [K_MAX];
   logic [K_MAX-1:0]      slot_filled_ff;
   logic [K_MAX-1:0]      slot_filled_in;
   logic [K_MAX-1:0]      ge;
   logic [SEEN_BITS-1:0]  items_seen_ff;
   logic [SEEN_BITS-1:0]  items_seen_in;
   logic                  dropped_ff;
   logic                  dropped_in;
   logic                  room;
   index_type             out_index_ff;
   logic                  out_valid_res_ff;
   logic                  out_final_ff;
   logic                  out_overflow_ff;

   assign room = items_seen_ff < SEEN_BITS'(N_MAX);

   // slot holds its place when it is filled and not beaten by the new score
   always_comb begin
      for (int i = 0; i < K_MAX; i++) begin
         ge[i] = slot_filled_ff[i] && (slot_score_ff[i] >= req_score);
      end
   end

   genvar g;
   generate
      for (g = 0; g < K_MAX; g++) begin : g_cell
         logic     prev_ge;
         score_type prev_score;
         index_type prev_index;
         logic     prev_filled;
         score_type next_score;
         index_type next_index;
         logic     next_filled;

         if (g == 0) begin : g_head
            assign prev_ge     = 1'b1;
            assign prev_score  = req_score;
            assign prev_index  = index_type'(0);
            assign prev_filled = 1'b0;
         end else begin : g_body
            assign prev_ge     = ge[g-1];
            assign prev_score  = slot_score_ff[g-1];
            assign prev_index  = slot_index_ff[g-1];
            assign prev_filled = slot_filled_ff[g-1];
         end

         if (g == K_MAX - 1) begin : g_tail
            assign next_score  = slot_score_ff[g];
            assign next_index  = slot_index_ff[g];
            assign next_filled = 1'b0;
         end else begin : g_mid
            assign next_score  = slot_score_ff[g+1];
            assign next_index  = slot_index_ff[g+1];
            assign next_filled = slot_filled_ff[g+1];
         end

         always_comb begin
            slot_score_in[g]  = slot_score_ff[g];
            slot_index_in[g]  = slot_index_ff[g];
            slot_filled_in[g] = slot_filled_ff[g];
            if (cmd.clear) begin
               slot_filled_in[g] = 1'b0;
            end else if (cmd.emit) begin
               slot_score_in[g]  = next_score;
               slot_index_in[g]  = next_index;
               slot_filled_in[g] = next_filled;
            end else if (cmd.insert && room && !ge[g]) begin
               if (prev_ge) begin
                  slot_score_in[g]  = req_score;
                  slot_index_in[g]  = items_seen_ff[IDX_BITS-1:0];
                  slot_filled_in[g] = 1'b1;
               end else begin
                  slot_score_in[g]  = prev_score;
                  slot_index_in[g]  = prev_index;
                  slot_filled_in[g] = prev_filled;
               end
            end
         end
      end
   endgenerate

   always_comb begin
      items_seen_in = items_seen_ff;
      dropped_in    = dropped_ff;
      if (cmd.clear) begin
         items_seen_in = '0;
         dropped_in    = 1'b0;
      end else if (cmd.insert) begin
         if (room) begin
            items_seen_in = items_seen_ff + SEEN_BITS'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_filled_ff <= '0;
         items_seen_ff  <= '0;
         dropped_ff     <= 1'b0;
      end else begin
         slot_filled_ff <= slot_filled_in;
         items_seen_ff  <= items_seen_in;
         dropped_ff     <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < K_MAX; i++) begin
         slot_score_ff[i] <= slot_score_in[i];
         slot_index_ff[i] <= slot_index_in[i];
      end
   end

   // output word register, loaded only on emit
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_index_ff     <= slot_filled_ff[0] ? slot_index_ff[0] : index_type'(0);
         out_valid_res_ff <= slot_filled_ff[0];
         out_final_ff     <= cmd.last_word;
         out_overflow_ff  <= dropped_ff;
      end
   end

   assign rsp_index     = out_index_ff;
   assign rsp_valid_res = out_valid_res_ff;
   assign rsp_final_res = out_final_ff;
   assign rsp_overflow  = out_overflow_ff;

endmodule

// ===== hw/rtl/tkis_ctrl.sv =====
module tkis_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 csr_we,
   input  tkis_pkg::sel_type    csr_wdata,
   output tkis_pkg::dp_cmd_type cmd
);
   import tkis_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic                 state_ff;
   logic                 state_in;
   logic [SLOT_BITS-1:0] count_ff;
   logic [SLOT_BITS-1:0] count_in;
   sel_type              select_count_ff;
   sel_type              k_eff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 accept;
   logic                 emit_go;
   logic                 last_word;

   // zero acts as one, anything above the slot count saturates
   always_comb begin
      if (select_count_ff == '0) begin
         k_eff = sel_type'(1);
      end else if (select_count_ff > sel_type'(K_MAX)) begin
         k_eff = sel_type'(K_MAX);
      end else begin
         k_eff = select_count_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign last_word = (sel_type'(count_ff) == k_eff - sel_type'(1));

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = ST_EMIT;
               count_in = '0;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               if (last_word) begin
                  state_in = ST_IDLE;
                  count_in = '0;
               end else begin
                  count_in = count_ff + SLOT_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cmd.insert    = accept;
      cmd.emit      = emit_go;
      cmd.last_word = last_word;
      cmd.clear     = emit_go && last_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         select_count_ff <= sel_type'(K_MAX);
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            select_count_ff <= csr_wdata;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
